### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, command and register codes and the cell type that the text
// console writer and its channel interfaces share.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'b1;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd15;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

endpackage

### design/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for console requests and for their results.
// ----------------------------------------------------------------------------
interface tcw_in_if #(
  parameter int ROW_W = 5,
  parameter int COL_W = 7
);
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::CMD_W-1:0] cmd;
  logic [tcw_pkg::CHAR_W-1:0] character;
  logic [ROW_W-1:0]          cell_row;
  logic [COL_W-1:0]          cell_col;

  modport source (output valid, cmd, character, cell_row, cell_col, input ready);
  modport sink   (input valid, cmd, character, cell_row, cell_col, output ready);
endinterface

interface tcw_out_if #(
  parameter int ROW_W = 5,
  parameter int COL_W = 7
);
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::CHAR_W-1:0] cell_character;
  logic [tcw_pkg::CHAR_W-1:0] cell_color;
  logic [ROW_W-1:0]           cursor_row;
  logic [COL_W-1:0]           cursor_column;

  modport source (output valid, cell_character, cell_color, cursor_row, cursor_column,
                  input ready);
  modport sink   (input valid, cell_character, cell_color, cursor_row, cursor_column,
                  output ready);
endinterface

### design/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console with a ROWS x COLUMNS cell memory, a cursor, scrolling
// and screen clear, driven by a small sequencer around one address unit.
//
//   Channel   Direction  Handshake          Payload
//   in_ch     in         valid / ready      cmd, character, cell_row, cell_col
//   out_ch    out        valid / ready      cell_character, cell_color, cursor
//   cfg_*     in         cfg_we only        cfg_idx, cfg_wdata
//
// A character passes through the write and done states, a read through read and
// done, and a newline or unused command through done alone. A clear writes each
// cell in turn through the single memory write port; a newline on the bottom row
// first scrolls. Reset is synchronous and resets the cursor, colours and control
// state, not the cell memory. A result waits in the output register while the
// next request is taken; a stalled result holds the sequencer only at its end.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  tcw_in_if.sink                              in_ch,
  tcw_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tcw_pkg::COLOR_W-1:0]         cfg_wdata
);

  localparam int TOTAL    = ROWS * COLUMNS;
  localparam int SCROLL_N = (ROWS - 1) * COLUMNS;
  localparam int AW       = $clog2(TOTAL);
  localparam int RW       = $clog2(ROWS);
  localparam int CW       = $clog2(COLUMNS + 1);
  localparam int ADW      = RW + CW + 1;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCROLL = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [RW-1:0]                 row_r, row_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [tcw_pkg::COLOR_W-1:0]   fg_r, fg_nxt;
  logic [tcw_pkg::COLOR_W-1:0]   bg_r, bg_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic [AW-1:0]                 cnt_r, cnt_nxt;
  logic                          pend_r, pend_nxt;
  logic [tcw_pkg::CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]    char_r, char_nxt;
  logic [RW-1:0]                 req_row_r, req_row_nxt;
  logic [CW-1:0]                 req_col_r, req_col_nxt;
  tcw_pkg::cell_t                out_cell_r, out_cell_nxt;
  logic [RW-1:0]                 out_row_r, out_row_nxt;
  logic [CW-1:0]                 out_col_r, out_col_nxt;

  tcw_pkg::cell_t                mem [TOTAL];
  tcw_pkg::cell_t                rd_q;
  logic                          mem_we;
  logic [AW-1:0]                 mem_wa;
  logic [AW-1:0]                 mem_ra;
  tcw_pkg::cell_t                mem_wd;

  logic [RW-1:0]                 sel_row;
  logic [CW-1:0]                 sel_col;
  logic [ADW-1:0]                addr_wide;
  logic [AW-1:0]                 cell_addr;
  logic [tcw_pkg::CHAR_W-1:0]    color;
  logic                          in_range;
  logic                          is_newline;
  logic                          line_full;

  // Shared cell address unit: the cursor when writing, else the requested cell.
  always_comb begin
    if (state_r == ST_WRITE) begin
      sel_row = row_r;
      sel_col = col_r;
    end else begin
      sel_row = req_row_r;
      sel_col = req_col_r;
    end
    addr_wide = ADW'(sel_row) * ADW'(COLUMNS) + ADW'(sel_col);
    cell_addr = addr_wide[AW-1:0];
  end

  assign color      = {bg_r, fg_r};
  assign in_range   = ((RW + 1)'(req_row_r) < (RW + 1)'(ROWS)) &&
                      ((CW + 1)'(req_col_r) < (CW + 1)'(COLUMNS));
  assign is_newline = (in_ch.character == tcw_pkg::CH_NEWLINE);
  assign line_full  = (col_r == CW'(COLUMNS));

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_character = out_cell_r.ch;
  assign out_ch.cell_color    = out_cell_r.attr;
  assign out_ch.cursor_row    = out_row_r;
  assign out_ch.cursor_column = out_col_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    char_nxt      = char_r;
    req_row_nxt   = req_row_r;
    req_col_nxt   = req_col_r;
    out_cell_nxt  = out_cell_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    mem_we        = 1'b0;
    mem_wa        = cnt_r;
    mem_wd        = '0;
    mem_ra        = cell_addr;

    if (cfg_we) begin
      unique case (cfg_idx)
        tcw_pkg::REG_FOREGROUND: fg_nxt = cfg_wdata;
        tcw_pkg::REG_BACKGROUND: bg_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt     = in_ch.cmd;
          char_nxt    = in_ch.character;
          req_row_nxt = in_ch.cell_row;
          req_col_nxt = in_ch.cell_col;
          pend_nxt    = 1'b0;
          case (in_ch.cmd)
            tcw_pkg::CMD_PUT: begin
              if (is_newline || line_full) begin
                col_nxt  = '0;
                pend_nxt = !is_newline;
                if (row_r == RW'(ROWS - 1)) begin
                  cnt_nxt   = '0;
                  state_nxt = ST_SCROLL;
                end else begin
                  row_nxt   = row_r + RW'(1);
                  state_nxt = is_newline ? ST_DONE : ST_WRITE;
                end
              end else begin
                state_nxt = ST_WRITE;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            tcw_pkg::CMD_READ: begin
              state_nxt = ST_READ;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // Read one row ahead and write the previous read back one row up.
        mem_ra = cnt_r + AW'(COLUMNS);
        if (cnt_r != '0) begin
          mem_we = 1'b1;
          mem_wa = cnt_r - AW'(1);
          mem_wd = rd_q;
        end
        if (cnt_r == AW'(SCROLL_N)) begin
          state_nxt = ST_FILL;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = '{attr: color, ch: tcw_pkg::CH_BLANK};
        if (cnt_r == AW'(TOTAL - 1)) begin
          state_nxt = pend_r ? ST_WRITE : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_wa    = cell_addr;
        mem_wd    = '{attr: color, ch: char_r};
        col_nxt   = col_r + CW'(1);
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = ((cmd_r == tcw_pkg::CMD_READ) && in_range) ? rd_q : '0;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      fg_r        <= tcw_pkg::FOREGROUND_RESET;
      bg_r        <= tcw_pkg::BACKGROUND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    req_row_r  <= req_row_nxt;
    req_col_r  <= req_col_nxt;
    out_cell_r <= out_cell_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("A second request was taken while one was in progress.");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) || (state_r == ST_DONE) || (state_r == ST_READ)) |-> !mem_we)
    else $error("The cell memory was written outside a write sequence.");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((RW + 1)'(row_r) < (RW + 1)'(ROWS)) && ((CW + 1)'(col_r) <= (CW + 1)'(COLUMNS)))
    else $error("The cursor left the screen.");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCROLL) && (cnt_r == '0)) |-> (row_r == RW'(ROWS - 1)))
    else $error("A scroll began with the cursor above the bottom row.");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives console requests and colour settings into the text console writer and
// checks every result against a local model of the cell store and the cursor.
// Directed tests cover field extremes, every command, line wrap and scrolling;
// random request sequences, with and without random idling on both channels, follow.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int ITEM_TARGET = 650;
  localparam int IDLE_PERCENT = 38;
  localparam int REPORT_LIMIT = 10;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 2010;

  localparam logic [tcw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [tcw_pkg::CHAR_W-1:0] cell_character;
    logic [tcw_pkg::CHAR_W-1:0] cell_color;
    logic [ROW_W-1:0]           cursor_row;
    logic [COL_W-1:0]           cursor_column;
  } console_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata;

  tcw_in_if  #(.ROW_W(ROW_W), .COL_W(COL_W)) in_ch ();
  tcw_out_if #(.ROW_W(ROW_W), .COL_W(COL_W)) out_ch ();

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  tcw_pkg::cell_t              screen_image [ROWS*COLUMNS];
  logic [ROW_W-1:0]            cursor_row_now;
  logic [COL_W-1:0]            cursor_col_now;
  logic [tcw_pkg::COLOR_W-1:0] foreground_now;
  logic [tcw_pkg::COLOR_W-1:0] background_now;

  console_result_t pending_results [$];
  bit no_idle;
  int requests_sent;
  int results_seen;
  int failure_count;
  int clear_count;
  int read_count;
  int wrap_count;
  int scroll_count;
  int cycle_count;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [tcw_pkg::CHAR_W-1:0] colour_byte();
    return {background_now, foreground_now};
  endfunction

  function automatic logic [tcw_pkg::CHAR_W-1:0] random_glyph();
    logic [tcw_pkg::CHAR_W-1:0] c;
    do c = tcw_pkg::CHAR_W'($urandom_range(255)); while (c == tcw_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic void start_new_line();
    cursor_col_now = '0;
    if (cursor_row_now < ROWS - 1) begin
      cursor_row_now++;
    end else begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
      for (int c = 0; c < COLUMNS; c++) begin
        screen_image[(ROWS - 1) * COLUMNS + c] = {colour_byte(), tcw_pkg::CH_BLANK};
      end
      scroll_count++;
    end
  endfunction

  function automatic console_result_t predict_console_result(
    input logic [tcw_pkg::CMD_W-1:0]  cmd,
    input logic [tcw_pkg::CHAR_W-1:0] character,
    input logic [ROW_W-1:0]           cell_row,
    input logic [COL_W-1:0]           cell_col
  );
    console_result_t result;
    int idx;
    result = '0;
    case (cmd)
      tcw_pkg::CMD_PUT: begin
        if (character == tcw_pkg::CH_NEWLINE) begin
          start_new_line();
        end else begin
          if (cursor_col_now >= COLUMNS) begin
            start_new_line();
            wrap_count++;
          end
          idx = int'(cursor_row_now) * COLUMNS + int'(cursor_col_now);
          screen_image[idx] = {colour_byte(), character};
          cursor_col_now++;
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < ROWS * COLUMNS; i++) begin
          screen_image[i] = {colour_byte(), tcw_pkg::CH_BLANK};
        end
        clear_count++;
      end
      tcw_pkg::CMD_READ: begin
        read_count++;
        if (cell_row < ROWS && cell_col < COLUMNS) begin
          idx = int'(cell_row) * COLUMNS + int'(cell_col);
          result.cell_character = screen_image[idx].ch;
          result.cell_color     = screen_image[idx].attr;
        end
      end
      default: begin
      end
    endcase
    result.cursor_row    = cursor_row_now;
    result.cursor_column = cursor_col_now;
    return result;
  endfunction

  task automatic note_failure(input string what, input console_result_t want,
                              input console_result_t seen);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) begin
      $display("%s at cycle %0d: expected char %02h colour %02h row %0d col %0d,",
               what, cycle_count, want.cell_character, want.cell_color,
               want.cursor_row, want.cursor_column);
      $display("  got char %02h colour %02h row %0d col %0d",
               seen.cell_character, seen.cell_color, seen.cursor_row, seen.cursor_column);
    end
  endtask

  // A request counts as taken at the rising edge that follows a falling edge
  // at which valid and ready are both high.
  task automatic send_request(
    input logic [tcw_pkg::CMD_W-1:0]  cmd,
    input logic [tcw_pkg::CHAR_W-1:0] character,
    input logic [ROW_W-1:0]           cell_row,
    input logic [COL_W-1:0]           cell_col
  );
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.character <= character;
    in_ch.cell_row  <= cell_row;
    in_ch.cell_col  <= cell_col;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    pending_results.push_back(predict_console_result(cmd, character, cell_row, cell_col));
    requests_sent++;
    @(posedge clk);
  endtask

  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [tcw_pkg::CFG_IDX_W-1:0] idx,
                                input logic [tcw_pkg::COLOR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcw_pkg::REG_FOREGROUND) foreground_now = value;
    else background_now = value;
    @(posedge clk);
  endtask

  always @(negedge clk) begin
    console_result_t seen;
    console_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.cell_character, out_ch.cell_color, out_ch.cursor_row, out_ch.cursor_column};
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure("Unexpected result", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen.cell_character !== want.cell_character || seen.cell_color !== want.cell_color ||
            seen.cursor_row !== want.cursor_row || seen.cursor_column !== want.cursor_column) begin
          note_failure("Result mismatch", want, seen);
        end
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  task automatic test_extremes();
    send_request(tcw_pkg::CMD_READ, 8'hFF, 5'd31, 7'd127);
    send_request(tcw_pkg::CMD_CLEAR, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, tcw_pkg::CH_NEWLINE, 5'd24, 7'd79);
    send_request(tcw_pkg::CMD_PUT, 8'h00, 5'd31, 7'd127);
    send_request(tcw_pkg::CMD_PUT, 8'hFF, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, 8'd9, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, 8'd11, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_BLANK, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, 8'd127, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, 8'd128, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd6);
    send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_request(CMD_UNUSED, 8'hA5, 5'd21, 7'd85);
    send_request(CMD_UNUSED, 8'h5A, 5'd10, 7'd42);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd25, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd80);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd127);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd0, 7'd7);
  endtask

  task automatic test_colour_settings();
    logic [tcw_pkg::COLOR_W-1:0] fg_list [5];
    logic [tcw_pkg::COLOR_W-1:0] bg_list [5];
    fg_list = '{4'd0, 4'd15, 4'd0, 4'd15, tcw_pkg::COLOR_W'($urandom_range(15))};
    bg_list = '{4'd0, 4'd15, 4'd15, 4'd0, tcw_pkg::COLOR_W'($urandom_range(15))};
    for (int s = 0; s < 5; s++) begin
      drain_requests();
      write_register(tcw_pkg::REG_FOREGROUND, fg_list[s]);
      write_register(tcw_pkg::REG_BACKGROUND, bg_list[s]);
      repeat ($urandom_range(1, 3)) send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
      send_request(tcw_pkg::CMD_READ, 8'h00, cursor_row_now, cursor_col_now - 7'd1);
      if (s == 2) begin
        send_request(tcw_pkg::CMD_CLEAR, random_glyph(), 5'd0, 7'd0);
        send_request(tcw_pkg::CMD_READ, 8'h00, 5'($urandom_range(ROWS - 1)),
                     7'($urandom_range(COLUMNS - 1)));
      end
      send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    end
  endtask

  task automatic test_line_wrap_and_scroll();
    while (cursor_col_now < COLUMNS) send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, cursor_row_now, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, cursor_row_now - 5'd1, 7'd79);
    while (cursor_row_now < ROWS - 1) begin
      send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    end
    send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'($urandom_range(COLUMNS - 1)));
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd23, 7'd0);
    while (cursor_col_now < COLUMNS) send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'd0, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd24, 7'd0);
    send_request(tcw_pkg::CMD_READ, 8'h00, 5'd23, 7'd79);
  endtask

  task automatic test_random_traffic(input int count);
    int stop_at;
    int kind;
    int len;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
        repeat (len) send_request(tcw_pkg::CMD_PUT, random_glyph(), 5'($urandom_range(31)),
                                  7'($urandom_range(127)));
        if ($urandom_range(1) == 1) begin
          send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE, 5'd0, 7'd0);
        end
      end else if (kind < 55) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(10, 26) : $urandom_range(1, 3);
        repeat (len) send_request(tcw_pkg::CMD_PUT, tcw_pkg::CH_NEWLINE,
                                  5'($urandom_range(31)), 7'($urandom_range(127)));
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(9) == 0) begin
            send_request(tcw_pkg::CMD_READ, 8'($urandom_range(255)), 5'($urandom_range(31)),
                         7'($urandom_range(127)));
          end else if ($urandom_range(1) == 1) begin
            send_request(tcw_pkg::CMD_READ, 8'($urandom_range(255)), cursor_row_now,
                         7'($urandom_range(COLUMNS - 1)));
          end else begin
            send_request(tcw_pkg::CMD_READ, 8'($urandom_range(255)),
                         5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLUMNS - 1)));
          end
        end
      end else if (kind < 90) begin
        send_request(tcw_pkg::CMD_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
                     7'($urandom_range(127)));
      end else begin
        send_request(($urandom_range(1) == 1) ? CMD_UNUSED
                                              : tcw_pkg::CMD_W'($urandom_range(3)),
                     8'($urandom_range(255)), 5'($urandom_range(31)), 7'($urandom_range(127)));
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(80);
    drain_requests();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = tcw_pkg::REG_FOREGROUND;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = tcw_pkg::CMD_PUT;
    in_ch.character = '0;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    no_idle         = 1'b0;
    cursor_row_now  = '0;
    cursor_col_now  = '0;
    foreground_now  = tcw_pkg::FOREGROUND_RESET;
    background_now  = tcw_pkg::BACKGROUND_RESET;
    foreach (screen_image[i]) screen_image[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_colour_settings();
    test_line_wrap_and_scroll();
    test_back_to_back();
    test_random_traffic(ITEM_TARGET - requests_sent);

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests and checked %0d results in %0d cycles.",
             requests_sent, results_seen, cycle_count);
    $display("The run took in %0d clears, %0d reads, %0d line wraps and %0d scrolls.",
             clear_count, read_count, wrap_count, scroll_count);
    if (failure_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/tcw_pkg.sv
design/tcw_if.sv
design/text_console_writer.sv
verif/testbench.sv
